// ----- sv/aps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg: shared types and helpers of the aging priority scheduler
// Request and result payloads, ready-list entry, cell control and key aging.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int unsigned NumTasksDefault = 32;
  localparam int unsigned TaskW           = 5;
  localparam int unsigned PrioW           = 7;

  localparam logic [PrioW-1:0] AgeCeilingReset = 7'd99;

  // request opcodes
  localparam logic OpMakeReady  = 1'b0;
  localparam logic OpReschedule = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] base_priority;
    logic             current_runnable;
  } req_t;

  typedef struct packed {
    logic [TaskW-1:0] running_id;
    logic             running_valid;
    logic             switched;
    logic             insert_dropped;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] key;
    logic [PrioW-1:0] base;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_AGE,
    CELL_POP_AGE,
    CELL_INSERT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] base;
    logic [PrioW-1:0] ceiling;
  } cell_ctrl_t;

  // ceil(6k/5) = k + ceil(k/5), capped; (k+4)/5 by reciprocal 205/1024
  function automatic logic [PrioW-1:0] age_key(input logic [PrioW-1:0] key,
                                               input logic [PrioW-1:0] ceiling);
    logic [15:0]      prod;
    logic [PrioW:0]   sum;
    prod = (16'(key) + 16'd4) * 16'd205;
    sum  = {1'b0, key} + {2'b00, prod[15:10]};
    if (sum > {1'b0, ceiling}) begin
      return ceiling;
    end
    return sum[PrioW-1:0];
  endfunction

endpackage

// ----- sv/aging_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_scheduler: ready-list scheduler with priority aging
// Sorted chain of slot cells plus the running-task register and control.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on res_o with res_valid_o high for exactly one cycle and cannot be stalled.
// For make-ready and most reschedule requests the result strobes in the
// cycle after acceptance and a new request may be taken in that same cycle.
// A reschedule that preempts a still runnable task holds busy high in the
// reinsertion state: the cell chain first shifts up and ages every key, then
// reinserts the old task, since each cell moves by one neighbor per clock.
// Configuration writes are meant for idle periods only.
module aging_priority_scheduler #(
  parameter int unsigned NUM_TASKS = aps_pkg::NumTasksDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  aps_pkg::req_t             req_i,
  output logic                      res_valid_o,
  output aps_pkg::res_t             res_o,
  input  logic                      cfg_we_i,
  input  logic [aps_pkg::PrioW-1:0] cfg_wdata_i
);

  typedef enum logic {
    ST_IDLE,
    ST_REINS
  } state_e;

  state_e                    state_q;
  logic [aps_pkg::PrioW-1:0] ceiling_q;
  logic                      run_valid_q;
  logic [aps_pkg::TaskW-1:0] run_task_q;
  logic [aps_pkg::PrioW-1:0] run_base_q;
  logic [aps_pkg::TaskW-1:0] old_task_q;
  logic [aps_pkg::PrioW-1:0] old_base_q;
  logic                      res_valid_q;
  aps_pkg::res_t             res_q;

  aps_pkg::entry_t     ents [NUM_TASKS];
  logic                stay [NUM_TASKS];
  aps_pkg::cell_ctrl_t ctrl;

  logic            accept;
  logic            full;
  logic            go_on;
  logic            keep_run;
  aps_pkg::entry_t top;

  assign accept   = start && (state_q == ST_IDLE);
  assign top      = ents[0];
  assign full     = ents[NUM_TASKS-1].valid;
  assign go_on    = req_i.current_runnable && run_valid_q;
  assign keep_run = go_on && (!top.valid || (top.key < run_base_q));

  always_comb begin
    ctrl.op      = aps_pkg::CELL_HOLD;
    ctrl.task_id = req_i.task_id;
    ctrl.base    = req_i.base_priority;
    ctrl.ceiling = ceiling_q;
    if (state_q == ST_REINS) begin
      ctrl.op      = aps_pkg::CELL_INSERT;
      ctrl.task_id = old_task_q;
      ctrl.base    = old_base_q;
    end else if (accept) begin
      if (req_i.opcode == aps_pkg::OpMakeReady) begin
        ctrl.op = full ? aps_pkg::CELL_HOLD : aps_pkg::CELL_INSERT;
      end else if (keep_run) begin
        ctrl.op = aps_pkg::CELL_AGE;
      end else if (top.valid) begin
        ctrl.op = aps_pkg::CELL_POP_AGE;
      end
    end
  end

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    aps_pkg::entry_t prev_ent;
    aps_pkg::entry_t next_ent;
    logic            prev_stay;
    if (i == 0) begin : g_first
      assign prev_ent  = '0;
      assign prev_stay = 1'b1;
    end else begin : g_inner
      assign prev_ent  = ents[i-1];
      assign prev_stay = stay[i-1];
    end
    if (i == NUM_TASKS - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ents[i+1];
    end
    aps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_i      (prev_ent),
      .prev_stay_i (prev_stay),
      .next_i      (next_ent),
      .ent_o       (ents[i]),
      .stay_o      (stay[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ceiling_q   <= aps_pkg::AgeCeilingReset;
      run_valid_q <= 1'b0;
      run_task_q  <= '0;
      run_base_q  <= '0;
      old_task_q  <= '0;
      old_base_q  <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        ceiling_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_valid_q <= 1'b1;
            res_q.running_id     <= run_valid_q ? run_task_q : '0;
            res_q.running_valid  <= run_valid_q;
            res_q.switched       <= 1'b0;
            res_q.insert_dropped <= 1'b0;
            if (req_i.opcode == aps_pkg::OpMakeReady) begin
              res_q.insert_dropped <= full;
            end else if (keep_run) begin
              // running task stays, keys only age
            end else if (!top.valid) begin
              run_valid_q          <= 1'b0;
              run_task_q           <= '0;
              run_base_q           <= '0;
              res_q.running_id     <= '0;
              res_q.running_valid  <= 1'b0;
              res_q.switched       <= run_valid_q;
            end else begin
              run_valid_q          <= 1'b1;
              run_task_q           <= top.task_id;
              run_base_q           <= top.base;
              res_q.running_id     <= top.task_id;
              res_q.running_valid  <= 1'b1;
              res_q.switched       <= 1'b1;
              if (go_on) begin
                // old task goes back in on the next cycle
                old_task_q  <= run_task_q;
                old_base_q  <= run_base_q;
                res_valid_q <= 1'b0;
                state_q     <= ST_REINS;
              end
            end
          end
        end
        ST_REINS: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !res_valid_o)
    else $error("result strobe while reinsertion pending");

  a_make_ready_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.opcode == aps_pkg::OpMakeReady) |=> (res_valid_o && !busy))
    else $error("make-ready result not delivered next cycle");

  a_reins_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (res_valid_o && res_o.switched && res_o.running_valid))
    else $error("reinsertion did not finish with a switch");

  a_idle_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.running_valid) |-> (res_o.running_id == '0))
    else $error("running id set with no running task");

  a_drop_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.insert_dropped) |-> !res_o.switched)
    else $error("dropped insert reported a switch");

endmodule

// ----- sv/aps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_cell: one slot of the sorted ready list
// Holds one entry; ages it, takes it from a neighbor on pop or insert.
// ----------------------------------------------------------------------------
module aps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aps_pkg::cell_ctrl_t ctrl_i,
  input  aps_pkg::entry_t     prev_i,
  input  logic                prev_stay_i,
  input  aps_pkg::entry_t     next_i,
  output aps_pkg::entry_t     ent_o,
  output logic                stay_o
);

  logic                      valid_q, valid_d;
  logic [aps_pkg::TaskW-1:0] task_q, task_d;
  logic [aps_pkg::PrioW-1:0] key_q, key_d;
  logic [aps_pkg::PrioW-1:0] base_q, base_d;

  // entry keeps its slot when it ranks at or above the new key
  assign stay_o = valid_q && (key_q >= ctrl_i.base);

  always_comb begin
    valid_d = valid_q;
    task_d  = task_q;
    key_d   = key_q;
    base_d  = base_q;
    unique case (ctrl_i.op)
      aps_pkg::CELL_HOLD: begin
      end
      aps_pkg::CELL_AGE: begin
        key_d = aps_pkg::age_key(key_q, ctrl_i.ceiling);
      end
      aps_pkg::CELL_POP_AGE: begin
        valid_d = next_i.valid;
        task_d  = next_i.task_id;
        key_d   = aps_pkg::age_key(next_i.key, ctrl_i.ceiling);
        base_d  = next_i.base;
      end
      aps_pkg::CELL_INSERT: begin
        if (!stay_o) begin
          if (prev_stay_i) begin
            valid_d = 1'b1;
            task_d  = ctrl_i.task_id;
            key_d   = ctrl_i.base;
            base_d  = ctrl_i.base;
          end else begin
            valid_d = prev_i.valid;
            task_d  = prev_i.task_id;
            key_d   = prev_i.key;
            base_d  = prev_i.base;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    key_q  <= key_d;
    base_q <= base_d;
  end

  assign ent_o.valid   = valid_q;
  assign ent_o.task_id = task_q;
  assign ent_o.key     = key_q;
  assign ent_o.base    = base_q;

endmodule

// ----- sim/aps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_checker: result checker for the aging priority scheduler
// Watches the request, result and config channels, keeps its own copy of the
// ready list and running task, and compares each result with the oldest
// predicted one. Counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module aps_checker
  import aps_pkg::*;
#(
  parameter int unsigned NUM_TASKS = NumTasksDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  req_t              req_i,
  input  logic              res_valid_i,
  input  res_t              res_i,
  input  logic              cfg_we_i,
  input  logic [PrioW-1:0]  cfg_wdata_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       switches_o,
  output int unsigned       drops_o
);

  typedef struct {
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] key;
    logic [PrioW-1:0] base;
  } ready_slot_t;

  ready_slot_t      ready_list[$];
  res_t             due_results[$];
  logic [TaskW-1:0] run_id;
  logic             run_on;
  logic [PrioW-1:0] run_prio;
  logic [PrioW-1:0] ceiling;
  int unsigned      n_mismatch, n_checked, n_switch, n_drop;

  // ceil(6k/5), saturated at the configured ceiling
  function automatic logic [PrioW-1:0] grow_key(input logic [PrioW-1:0] k);
    int unsigned g;
    g = (int'(k) * 6 + 4) / 5;
    if (g > ceiling) g = ceiling;
    return g[PrioW-1:0];
  endfunction

  function automatic void age_ready_list();
    foreach (ready_list[i]) ready_list[i].key = grow_key(ready_list[i].key);
  endfunction

  // sorted insert, behind every entry with an equal or higher key
  function automatic bit enqueue_ready(input logic [TaskW-1:0] id,
                                       input logic [PrioW-1:0] prio);
    ready_slot_t s;
    int          pos;
    if (ready_list.size() >= NUM_TASKS) return 1'b0;
    pos = 0;
    while (pos < ready_list.size() && ready_list[pos].key >= prio) pos++;
    s.task_id = id;
    s.key     = prio;
    s.base    = prio;
    ready_list.insert(pos, s);
    return 1'b1;
  endfunction

  function automatic res_t predict_schedule(input req_t r);
    res_t             res;
    bit               keep_going;
    ready_slot_t      top;
    logic [TaskW-1:0] old_id;
    logic [PrioW-1:0] old_prio;
    res = '0;
    if (r.opcode == OpMakeReady) begin
      res.insert_dropped = !enqueue_ready(r.task_id, r.base_priority);
    end else begin
      keep_going = r.current_runnable && run_on;
      if (keep_going && (ready_list.size() == 0 || ready_list[0].key < run_prio)) begin
        age_ready_list();
      end else if (ready_list.size() == 0) begin
        res.switched = run_on;
        run_on   = 1'b0;
        run_id   = '0;
        run_prio = '0;
      end else begin
        old_id   = run_id;
        old_prio = run_prio;
        top      = ready_list.pop_front();
        run_id   = top.task_id;
        run_prio = top.base;
        run_on   = 1'b1;
        res.switched = 1'b1;
        age_ready_list();
        // preempted task goes back in at its base, not aged
        if (keep_going) void'(enqueue_ready(old_id, old_prio));
      end
    end
    res.running_valid = run_on;
    res.running_id    = run_on ? run_id : '0;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_mismatch++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      ready_list.delete();
      due_results.delete();
      run_id     = '0;
      run_on     = 1'b0;
      run_prio   = '0;
      ceiling    = AgeCeilingReset;
      n_mismatch = 0;
      n_checked  = 0;
      n_switch   = 0;
      n_drop     = 0;
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          n_mismatch++;
          $display("%0t: result with none pending, expected nothing actual %h",
                   $time, res_i);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          check_field("running_id", want.running_id, res_i.running_id);
          check_field("running_valid", want.running_valid, res_i.running_valid);
          check_field("switched", want.switched, res_i.switched);
          check_field("insert_dropped", want.insert_dropped, res_i.insert_dropped);
        end
      end
      if (cfg_we_i) ceiling = cfg_wdata_i;
      if (start && !busy) begin
        want = predict_schedule(req_i);
        if (want.switched) n_switch++;
        if (want.insert_dropped) n_drop++;
        due_results.push_back(want);
      end
    end
    mismatches_o <= n_mismatch;
    pending_o    <= due_results.size();
    checked_o    <= n_checked;
    switches_o   <= n_switch;
    drops_o      <= n_drop;
  end

endmodule

// ----- sim/aging_priority_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_scheduler_tb: testbench top for the aging priority scheduler
// Directed requests for the corner cases, then random phases under several
// age ceilings with bursty idling; results are checked by aps_checker.
// ----------------------------------------------------------------------------
module aging_priority_scheduler_tb;
  import aps_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             req;
  logic             res_valid;
  res_t             res;
  logic             cfg_we;
  logic [PrioW-1:0] cfg_wdata;

  int unsigned mismatches, pending, checked, switches, drops;
  int unsigned n_make, n_resched, n_ceilings;

  aging_priority_scheduler #(
    .NUM_TASKS (NumTasksDefault)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  aps_checker #(
    .NUM_TASKS (NumTasksDefault)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .switches_o   (switches),
    .drops_o      (drops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // extremes show up often enough to hit ceiling and equal-key cases
  function automatic logic [PrioW-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PrioW'($urandom);
  endfunction

  // fields a request ignores still get random values
  function automatic req_t build_req(input logic op, input logic [TaskW-1:0] id,
                                     input logic [PrioW-1:0] prio,
                                     input logic runnable);
    req_t r;
    r.opcode           = op;
    r.task_id          = (op == OpMakeReady) ? id : TaskW'($urandom);
    r.base_priority    = (op == OpMakeReady) ? prio : PrioW'($urandom);
    r.current_runnable = (op == OpReschedule) ? runnable : 1'($urandom);
    return r;
  endfunction

  task automatic issue(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    if (r.opcode == OpMakeReady) n_make++;
    else n_resched++;
  endtask

  task automatic make_ready(input logic [TaskW-1:0] id, input logic [PrioW-1:0] prio);
    issue(build_req(OpMakeReady, id, prio, 1'b0));
  endtask

  task automatic reschedule(input logic runnable);
    issue(build_req(OpReschedule, '0, '0, runnable));
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_ceiling(input logic [PrioW-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_ceilings++;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned make_pct,
                              input int unsigned idle_pct);
    logic op;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end
      op = ($urandom_range(99) < make_pct) ? OpMakeReady : OpReschedule;
      issue(build_req(op, TaskW'($urandom), pick_prio(), $urandom_range(9) < 7));
    end
  endtask

  initial begin
    n_make     = 0;
    n_resched  = 0;
    n_ceilings = 1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset ceiling
    reschedule(1'b1);          // runnable flag with nothing running
    make_ready(5'd31, 7'd127);
    make_ready(5'd0, 7'd0);
    make_ready(5'd21, 7'd127); // equal key, queued behind task 31
    reschedule(1'b0);          // idle cpu takes the top entry
    reschedule(1'b1);          // running base beats aged top, keeps running
    make_ready(5'd10, 7'd127);
    reschedule(1'b1);          // equal key preempts, old task reinserted
    reschedule(1'b1);
    reschedule(1'b0);
    reschedule(1'b0);
    reschedule(1'b0);
    reschedule(1'b1);          // empty list, runnable task stays
    reschedule(1'b0);          // empty list, cpu goes idle
    reschedule(1'b0);          // still idle, no switch
    make_ready(5'd7, 7'd50);
    make_ready(5'd7, 7'd50);   // same id twice
    reschedule(1'b0);
    reschedule(1'b1);          // top entry carries the same id
    // fill the ready list past full
    for (int unsigned i = 0; i < NumTasksDefault + 2; i++) begin
      make_ready(TaskW'($urandom), pick_prio());
    end

    write_ceiling(7'd127);
    random_phase(150, 60, 30);
    write_ceiling(7'd0);
    random_phase(100, 50, 20);
    write_ceiling(7'd1);
    random_phase(100, 85, 40);
    write_ceiling(PrioW'($urandom));
    random_phase(150, 45, 0);
    write_ceiling(AgeCeilingReset);
    random_phase(150, 55, 25);
    write_ceiling(PrioW'($urandom_range(100, 40)));
    random_phase(100, 50, 0);

    settle();
    repeat (4) @(posedge clk);

    $display("run covered %0d requests (%0d make-ready, %0d reschedule) under %0d ceilings",
             n_make + n_resched, n_make, n_resched, n_ceilings);
    $display("%0d results checked, %0d task switches, %0d dropped inserts",
             checked, switches, drops);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
